// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the frame buffer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rstn, pre, post)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post)

`endif

`endif

// ===== hw/rtl/rlsfb_pkg.sv =====
// ----------------------------------------------------------------------------
// rlsfb_pkg
// Types, constants and the palette table of the LED strip frame buffer.
// ----------------------------------------------------------------------------
package rlsfb_pkg;

  localparam int unsigned MaxLeds    = 16;
  localparam int unsigned StoreBytes = 3 * MaxLeds;
  localparam int unsigned AddrW      = $clog2(StoreBytes);
  localparam int unsigned StepW      = $clog2(StoreBytes + 4);
  localparam int unsigned CountW     = 5;
  localparam int unsigned PalBytes   = 96;
  localparam int unsigned PalAddrW   = $clog2(PalBytes);

  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [StepW-1:0]  step_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [7:0]        byte_t;

  localparam count_t LedsReset = count_t'(7);

  typedef enum logic [2:0] {
    REQ_SET_RGB  = 3'd0,
    REQ_SET_PAL  = 3'd1,
    REQ_ROT_UP   = 3'd2,
    REQ_ROT_DOWN = 3'd3,
    REQ_CLEAR    = 3'd4,
    REQ_SHOW     = 3'd5
  } req_type_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] led_index;
    byte_t      red;
    byte_t      green;
    byte_t      blue;
    logic [4:0] palette_index;
  } req_t;

  typedef struct packed {
    byte_t strip_byte;
    logic  last_byte;
  } res_t;

  // Memory request from the sequencer.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    byte_t wdata;
    addr_t raddr;
  } mem_req_t;

  // EGA palette as red, green, blue triples; 16 dark entries, then 16 bright.
  localparam byte_t EgaRom [PalBytes] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h03, 8'h00, 8'h00, 8'h03, 8'h03,
    8'h03, 8'h00, 8'h00, 8'h03, 8'h00, 8'h03, 8'h03, 8'h01, 8'h00, 8'h03, 8'h03, 8'h03,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h06, 8'h01, 8'h06, 8'h01, 8'h01, 8'h06, 8'h06,
    8'h06, 8'h01, 8'h01, 8'h06, 8'h01, 8'h06, 8'h06, 8'h06, 8'h01, 8'h06, 8'h06, 8'h06,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'haa, 8'h00, 8'haa, 8'h00, 8'h00, 8'haa, 8'haa,
    8'haa, 8'h00, 8'h00, 8'haa, 8'h00, 8'haa, 8'haa, 8'h55, 8'h00, 8'haa, 8'haa, 8'haa,
    8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'hff, 8'h55, 8'hff, 8'h55, 8'h55, 8'hff, 8'hff,
    8'hff, 8'h55, 8'h55, 8'hff, 8'h55, 8'hff, 8'hff, 8'hff, 8'h55, 8'hff, 8'hff, 8'hff
  };

  // Number of store bytes covered by the LED count register, saturated.
  function automatic step_t active_bytes(input count_t leds);
    count_t n;
    step_t  nb;
    n  = (leds > count_t'(MaxLeds)) ? count_t'(MaxLeds) : leds;
    nb = step_t'(n);
    return (nb << 1) + nb;
  endfunction

endpackage

// ===== hw/rtl/rlsfb_ram.sv =====
// ----------------------------------------------------------------------------
// rlsfb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rlsfb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 48
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rlsfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlsfb_ctrl
// Command sequencer: set, rotate, clear and show walks over the frame store.
// ----------------------------------------------------------------------------
module rlsfb_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  rlsfb_pkg::req_t          req_i,
  input  logic                     cfg_we_i,
  input  rlsfb_pkg::count_t        cfg_wdata_i,
  input  rlsfb_pkg::byte_t         rdata_i,
  output rlsfb_pkg::mem_req_t      mem_req_o,
  output logic                     res_valid_o,
  output rlsfb_pkg::res_t          res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET,
    ST_ROT,
    ST_SHOW,
    ST_FILL
  } state_e;

  state_e              state_q, state_d;
  rlsfb_pkg::step_t    step_q, step_d;
  rlsfb_pkg::count_t   leds_q;
  logic                res_valid_q, res_valid_d;
  rlsfb_pkg::res_t     res_q, res_d;

  rlsfb_pkg::step_t    bytes_q;
  logic                up_q;
  rlsfb_pkg::addr_t    base_q;
  rlsfb_pkg::byte_t    col_q [3];
  rlsfb_pkg::byte_t    sreg_q [3];

  rlsfb_pkg::step_t    bytes_cur;
  rlsfb_pkg::step_t    idx_bytes;
  rlsfb_pkg::step_t    step_nx;
  logic                accept;
  logic                in_range;
  logic                rot_ok;
  logic                shift_en;
  logic [rlsfb_pkg::PalAddrW-1:0] pal_base;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign bytes_cur = rlsfb_pkg::active_bytes(leds_q);
  assign idx_bytes = (rlsfb_pkg::step_t'(req_i.led_index) << 1)
                   + rlsfb_pkg::step_t'(req_i.led_index);
  assign in_range  = idx_bytes < bytes_cur;
  assign rot_ok    = bytes_cur > rlsfb_pkg::step_t'(3);
  assign step_nx   = step_q + rlsfb_pkg::step_t'(1);
  assign pal_base  = (rlsfb_pkg::PalAddrW'(req_i.palette_index) << 1)
                   + rlsfb_pkg::PalAddrW'(req_i.palette_index);

  // Rotation streams the store through a three-byte delay line. Rotate up
  // seeds it with the last LED and then moves every byte three places up.
  // Rotate down seeds it with the first LED, moves every byte three places
  // down straight from the read data, and drains the first LED at the end.
  assign shift_en = up_q || (step_q < rlsfb_pkg::step_t'(3)) || (step_q >= bytes_q);

  always_comb begin
    mem_req_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            rlsfb_pkg::REQ_ROT_UP: begin
              if (rot_ok) begin
                mem_req_o.raddr = rlsfb_pkg::addr_t'(bytes_cur - rlsfb_pkg::step_t'(3));
              end
            end
            default: begin
              mem_req_o.raddr = '0;
            end
          endcase
        end
      end
      ST_SET: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = base_q + rlsfb_pkg::addr_t'(step_q);
        mem_req_o.wdata = col_q[step_q[1:0]];
      end
      ST_ROT: begin
        if (step_q >= rlsfb_pkg::step_t'(3)) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = rlsfb_pkg::addr_t'(step_q - rlsfb_pkg::step_t'(3));
          mem_req_o.wdata = (!up_q && (step_q < bytes_q)) ? rdata_i : sreg_q[2];
        end
        if (up_q) begin
          if (step_nx < rlsfb_pkg::step_t'(3)) begin
            mem_req_o.raddr = rlsfb_pkg::addr_t'(bytes_q - rlsfb_pkg::step_t'(3) + step_nx);
          end else if (step_nx <= bytes_q + rlsfb_pkg::step_t'(2)) begin
            mem_req_o.raddr = rlsfb_pkg::addr_t'(step_nx - rlsfb_pkg::step_t'(3));
          end
        end else if (step_nx < bytes_q) begin
          mem_req_o.raddr = rlsfb_pkg::addr_t'(step_nx);
        end
      end
      ST_SHOW: begin
        if (step_nx < bytes_q) begin
          mem_req_o.raddr = rlsfb_pkg::addr_t'(step_nx);
        end
      end
      ST_FILL: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = rlsfb_pkg::addr_t'(step_q);
        mem_req_o.wdata = '0;
      end
      default: begin
        mem_req_o = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (accept) begin
          case (req_i.req_type)
            rlsfb_pkg::REQ_SET_RGB, rlsfb_pkg::REQ_SET_PAL: begin
              if (in_range) begin
                state_d = ST_SET;
              end
            end
            rlsfb_pkg::REQ_ROT_UP, rlsfb_pkg::REQ_ROT_DOWN: begin
              if (rot_ok) begin
                state_d = ST_ROT;
              end
            end
            rlsfb_pkg::REQ_CLEAR: begin
              if (bytes_cur != '0) begin
                state_d = ST_FILL;
              end
            end
            rlsfb_pkg::REQ_SHOW: begin
              if (bytes_cur != '0) begin
                state_d = ST_SHOW;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SET: begin
        step_d = step_nx;
        if (step_q == rlsfb_pkg::step_t'(2)) begin
          state_d = ST_IDLE;
        end
      end
      ST_ROT: begin
        step_d = step_nx;
        if (step_q == bytes_q + rlsfb_pkg::step_t'(2)) begin
          state_d = ST_IDLE;
        end
      end
      ST_SHOW: begin
        step_d               = step_nx;
        res_valid_d          = 1'b1;
        res_d.strip_byte     = rdata_i;
        res_d.last_byte      = (step_nx == bytes_q);
        if (step_nx == bytes_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_FILL: begin
        step_d = step_nx;
        if (step_nx == bytes_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Reset starts a zero fill over the whole store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      step_q      <= '0;
      bytes_q     <= rlsfb_pkg::step_t'(rlsfb_pkg::StoreBytes);
      leds_q      <= rlsfb_pkg::LedsReset;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
      if (accept) begin
        bytes_q <= bytes_cur;
      end
      if (cfg_we_i) begin
        leds_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_q    <= (req_i.req_type == rlsfb_pkg::REQ_ROT_UP);
      base_q  <= rlsfb_pkg::addr_t'(idx_bytes);
      if (req_i.req_type == rlsfb_pkg::REQ_SET_PAL) begin
        col_q[0] <= rlsfb_pkg::EgaRom[pal_base + rlsfb_pkg::PalAddrW'(1)];
        col_q[1] <= rlsfb_pkg::EgaRom[pal_base];
        col_q[2] <= rlsfb_pkg::EgaRom[pal_base + rlsfb_pkg::PalAddrW'(2)];
      end else begin
        col_q[0] <= req_i.green;
        col_q[1] <= req_i.red;
        col_q[2] <= req_i.blue;
      end
    end
    if ((state_q == ST_ROT) && shift_en) begin
      sreg_q[2] <= sreg_q[1];
      sreg_q[1] <= sreg_q[0];
      sreg_q[0] <= rdata_i;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/rgb_led_strip_frame_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_led_strip_frame_buffer_unit
// Frame buffer for a WS2812 LED strip: per-LED green, red, blue bytes.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Transfer
//   command   start, busy, req_i             start high while busy is low
//   result    res_valid_o, res_o             one cycle per strobe, no stall
//   config    cfg_we_i, cfg_wdata_i          every cycle cfg_we_i is high
//
// Set writes one LED; clear, rotate and show walk the LEDs in use;
// the frame store RAM moves one byte per cycle, and that sets the rate. A show
// delivers one byte per cycle, the last one strobed in the first cycle busy is
// low again. After reset busy stays high while every store byte is written
// with zero. The receiver cannot stall the result stream.
//
`include "assert_macros.svh"

module rgb_led_strip_frame_buffer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rlsfb_pkg::req_t     req_i,
  input  logic                cfg_we_i,
  input  rlsfb_pkg::count_t   cfg_wdata_i,
  output logic                res_valid_o,
  output rlsfb_pkg::res_t     res_o
);

  rlsfb_pkg::mem_req_t mem_req;
  rlsfb_pkg::byte_t    rdata;
  logic                cmd_no_show;
  logic                wr_in_store;

  rlsfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rdata_i     (rdata),
    .mem_req_o   (mem_req),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  rlsfb_ram #(
    .Width (8),
    .Depth (rlsfb_pkg::StoreBytes)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  assign cmd_no_show = start && !busy && (req_i.req_type != rlsfb_pkg::REQ_SHOW);
  assign wr_in_store = int'(mem_req.waddr) < rlsfb_pkg::StoreBytes;

  `ASSERT_IMPLY(a_res_after_busy, clk_i, rst_ni, res_valid_o, $past(busy))
  `ASSERT_IMPLY(a_last_ends_show, clk_i, rst_ni, res_valid_o && res_o.last_byte, !busy)
  `ASSERT_NEXT(a_no_res_after_cmd, clk_i, rst_ni, cmd_no_show, !res_valid_o)
  `ASSERT_IMPLY(a_wr_in_store, clk_i, rst_ni, mem_req.we, wr_in_store)

endmodule

// ===== sim/tb_rgb_led_strip_frame_buffer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_led_strip_frame_buffer_unit
// Self-checking testbench for the LED strip frame buffer. It sends set,
// rotate, clear and show commands, keeps a shadow copy of the frame store,
// and compares every streamed byte and its last flag with that copy.
// ----------------------------------------------------------------------------
module tb_rgb_led_strip_frame_buffer_unit;

  localparam int unsigned QuietLimit   = 5000;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned PhaseItems   = 29;
  localparam int unsigned PhaseCount   = 12;

  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  // Palette colors packed as {red, green, blue}.
  localparam logic [23:0] PaletteRgb [32] = '{
    24'h000000, 24'h000003, 24'h000300, 24'h000303,
    24'h030000, 24'h030003, 24'h030100, 24'h030303,
    24'h010101, 24'h010106, 24'h010601, 24'h010606,
    24'h060101, 24'h060106, 24'h060601, 24'h060606,
    24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
    24'haa0000, 24'haa00aa, 24'haa5500, 24'haaaaaa,
    24'h555555, 24'h5555ff, 24'h55ff55, 24'h55ffff,
    24'hff5555, 24'hff55ff, 24'hffff55, 24'hffffff
  };

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  rlsfb_pkg::req_t   req_i       = '0;
  logic              cfg_we_i    = 1'b0;
  rlsfb_pkg::count_t cfg_wdata_i = '0;
  logic              res_valid_o;
  rlsfb_pkg::res_t   res_o;

  rlsfb_pkg::byte_t  frame_model [rlsfb_pkg::StoreBytes];
  rlsfb_pkg::count_t led_count;
  rlsfb_pkg::res_t   strip_bytes_due [$];
  int unsigned       gap_pct;
  int unsigned       error_count  = 0;
  int unsigned       quiet_cycles = 0;

  rgb_led_strip_frame_buffer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned covered_leds();
    return (led_count > rlsfb_pkg::MaxLeds) ? rlsfb_pkg::MaxLeds : int'(led_count);
  endfunction

  // Updates the shadow store for one accepted command and queues show bytes.
  function automatic void apply_command(input rlsfb_pkg::req_t cmd);
    int unsigned      n;
    int unsigned      base;
    int               k;
    int               j;
    logic [23:0]      rgb;
    rlsfb_pkg::byte_t held [3];
    rlsfb_pkg::res_t  due;
    n    = covered_leds();
    base = 3 * cmd.led_index;
    case (cmd.req_type)
      rlsfb_pkg::REQ_SET_RGB, rlsfb_pkg::REQ_SET_PAL: begin
        rgb = (cmd.req_type == rlsfb_pkg::REQ_SET_RGB) ? {cmd.red, cmd.green, cmd.blue}
                                                       : PaletteRgb[cmd.palette_index];
        if (cmd.led_index < n) begin
          frame_model[base]     = rgb[15:8];
          frame_model[base + 1] = rgb[23:16];
          frame_model[base + 2] = rgb[7:0];
        end
      end
      rlsfb_pkg::REQ_ROT_UP: begin
        if (n > 1) begin
          for (j = 0; j < 3; j++) held[j] = frame_model[3 * (n - 1) + j];
          for (k = 3 * n - 1; k >= 3; k--) frame_model[k] = frame_model[k - 3];
          for (j = 0; j < 3; j++) frame_model[j] = held[j];
        end
      end
      rlsfb_pkg::REQ_ROT_DOWN: begin
        if (n > 1) begin
          for (j = 0; j < 3; j++) held[j] = frame_model[j];
          for (k = 0; k < 3 * n - 3; k++) frame_model[k] = frame_model[k + 3];
          for (j = 0; j < 3; j++) frame_model[3 * (n - 1) + j] = held[j];
        end
      end
      rlsfb_pkg::REQ_CLEAR: begin
        for (k = 0; k < 3 * n; k++) frame_model[k] = '0;
      end
      rlsfb_pkg::REQ_SHOW: begin
        for (k = 0; k < 3 * n; k++) begin
          due.strip_byte = frame_model[k];
          due.last_byte  = (k + 1 == 3 * n);
          strip_bytes_due.push_back(due);
        end
      end
      default: ;
    endcase
  endfunction

  // Result check first, then prediction for a command taken at this edge.
  always @(posedge clk_i) begin : check_and_predict
    rlsfb_pkg::res_t want;
    if (rst_ni) begin
      if (res_valid_o) begin
        if (strip_bytes_due.size() == 0) begin
          $display("%0t: unexpected byte: expected none, actual %h last %b",
                   $time, res_o.strip_byte, res_o.last_byte);
          error_count++;
        end else begin
          want = strip_bytes_due.pop_front();
          if (res_o.strip_byte !== want.strip_byte) begin
            $display("%0t: strip_byte mismatch: expected %h, actual %h",
                     $time, want.strip_byte, res_o.strip_byte);
            error_count++;
          end
          if (res_o.last_byte !== want.last_byte) begin
            $display("%0t: last_byte mismatch: expected %b, actual %b",
                     $time, want.last_byte, res_o.last_byte);
            error_count++;
          end
        end
      end
      if (start && !busy) apply_command(req_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic rlsfb_pkg::req_t make_req(input logic [2:0] kind,
                                               input logic [3:0] idx,
                                               input rlsfb_pkg::byte_t r,
                                               input rlsfb_pkg::byte_t g,
                                               input rlsfb_pkg::byte_t b,
                                               input logic [4:0] pal);
    rlsfb_pkg::req_t cmd;
    cmd.req_type      = kind;
    cmd.led_index     = idx;
    cmd.red           = r;
    cmd.green         = g;
    cmd.blue          = b;
    cmd.palette_index = pal;
    return cmd;
  endfunction

  function automatic rlsfb_pkg::req_t rand_req();
    rlsfb_pkg::req_t cmd;
    logic [63:0]     raw;
    int unsigned     pick;
    int unsigned     n;
    raw  = {$urandom, $urandom};
    cmd  = raw[$bits(rlsfb_pkg::req_t)-1:0];
    n    = covered_leds();
    pick = $urandom_range(99);
    if (pick < 40)      cmd.req_type = rlsfb_pkg::REQ_SET_RGB;
    else if (pick < 60) cmd.req_type = rlsfb_pkg::REQ_SET_PAL;
    else if (pick < 68) cmd.req_type = rlsfb_pkg::REQ_ROT_UP;
    else if (pick < 76) cmd.req_type = rlsfb_pkg::REQ_ROT_DOWN;
    else if (pick < 80) cmd.req_type = rlsfb_pkg::REQ_CLEAR;
    else if (pick < 96) cmd.req_type = rlsfb_pkg::REQ_SHOW;
    else cmd.req_type = $urandom_range(1) ? REQ_SPARE_7 : REQ_SPARE_6;
    // Most set commands land on a covered LED so that they change the store.
    if (n > 0 && $urandom_range(9) < 8) cmd.led_index = 4'($urandom_range(n - 1, 0));
    return cmd;
  endfunction

  // One command transfer. Start stays high into the next call when no gap
  // is drawn, so back-to-back commands need no idle cycle.
  task automatic send_cmd(input rlsfb_pkg::req_t cmd);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= cmd;
    do @(posedge clk_i); while (busy);
  endtask

  // Holds the sender off until every queued byte has arrived and any
  // rotate or clear still in flight has finished.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (strip_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_led_count(input rlsfb_pkg::count_t value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    led_count  = value;
  endtask

  task automatic test_reset_state();
    send_cmd(make_req(rlsfb_pkg::REQ_SHOW, 4'd0, 8'h00, 8'h00, 8'h00, 5'd0));
  endtask

  task automatic test_set_rgb();
    send_cmd(make_req(rlsfb_pkg::REQ_SET_RGB, 4'd0, 8'hff, 8'h00, 8'haa, 5'd31));
    send_cmd(make_req(rlsfb_pkg::REQ_SET_RGB, 4'd6, 8'h00, 8'hff, 8'h55, 5'd0));
    // Indexes at and past the LED count must leave the store alone.
    send_cmd(make_req(rlsfb_pkg::REQ_SET_RGB, 4'd7, 8'h12, 8'h34, 8'h56, 5'd0));
    send_cmd(make_req(rlsfb_pkg::REQ_SET_RGB, 4'd15, 8'hff, 8'hff, 8'hff, 5'd31));
    send_cmd(make_req(rlsfb_pkg::REQ_SHOW, 4'd0, 8'h00, 8'h00, 8'h00, 5'd0));
  endtask

  task automatic test_set_palette();
    send_cmd(make_req(rlsfb_pkg::REQ_SET_PAL, 4'd1, 8'hff, 8'hff, 8'hff, 5'd0));
    send_cmd(make_req(rlsfb_pkg::REQ_SET_PAL, 4'd2, 8'h00, 8'h00, 8'h00, 5'd31));
    send_cmd(make_req(rlsfb_pkg::REQ_SET_PAL, 4'd3, 8'h00, 8'h00, 8'h00, 5'd22));
    send_cmd(make_req(rlsfb_pkg::REQ_SET_PAL, 4'd4, 8'h00, 8'h00, 8'h00, 5'd13));
    send_cmd(make_req(rlsfb_pkg::REQ_SHOW, 4'd0, 8'h00, 8'h00, 8'h00, 5'd0));
  endtask

  task automatic test_rotate();
    send_cmd(make_req(rlsfb_pkg::REQ_ROT_UP, 4'd0, 8'h00, 8'h00, 8'h00, 5'd0));
    send_cmd(make_req(rlsfb_pkg::REQ_SHOW, 4'd0, 8'h00, 8'h00, 8'h00, 5'd0));
    send_cmd(make_req(rlsfb_pkg::REQ_ROT_DOWN, 4'd0, 8'h00, 8'h00, 8'h00, 5'd0));
    send_cmd(make_req(rlsfb_pkg::REQ_ROT_DOWN, 4'd0, 8'h00, 8'h00, 8'h00, 5'd0));
  endtask

  task automatic test_spare_codes();
    send_cmd(make_req(REQ_SPARE_6, 4'd0, 8'hff, 8'hff, 8'hff, 5'd31));
    send_cmd(make_req(REQ_SPARE_7, 4'd15, 8'hff, 8'hff, 8'hff, 5'd31));
  endtask

  task automatic test_led_count();
    write_led_count(rlsfb_pkg::count_t'(16));
    send_cmd(make_req(rlsfb_pkg::REQ_SET_RGB, 4'd15, 8'h81, 8'h42, 8'h24, 5'd0));
    send_cmd(make_req(rlsfb_pkg::REQ_SHOW, 4'd0, 8'h00, 8'h00, 8'h00, 5'd0));
    // With no LED covered every command is a no-op and show streams nothing.
    write_led_count(rlsfb_pkg::count_t'(0));
    send_cmd(make_req(rlsfb_pkg::REQ_SET_RGB, 4'd0, 8'hff, 8'hff, 8'hff, 5'd0));
    send_cmd(make_req(rlsfb_pkg::REQ_ROT_UP, 4'd0, 8'h00, 8'h00, 8'h00, 5'd0));
    send_cmd(make_req(rlsfb_pkg::REQ_CLEAR, 4'd0, 8'h00, 8'h00, 8'h00, 5'd0));
    send_cmd(make_req(rlsfb_pkg::REQ_SHOW, 4'd0, 8'h00, 8'h00, 8'h00, 5'd0));
    write_led_count(rlsfb_pkg::count_t'(1));
    send_cmd(make_req(rlsfb_pkg::REQ_ROT_UP, 4'd0, 8'h00, 8'h00, 8'h00, 5'd0));
    send_cmd(make_req(rlsfb_pkg::REQ_SHOW, 4'd0, 8'h00, 8'h00, 8'h00, 5'd0));
    // A clear over seven LEDs must keep the bytes of the upper ones.
    write_led_count(rlsfb_pkg::count_t'(7));
    send_cmd(make_req(rlsfb_pkg::REQ_CLEAR, 4'd0, 8'h00, 8'h00, 8'h00, 5'd0));
    write_led_count(rlsfb_pkg::count_t'(31));
    send_cmd(make_req(rlsfb_pkg::REQ_SHOW, 4'd0, 8'h00, 8'h00, 8'h00, 5'd0));
  endtask

  task automatic test_random_traffic();
    int unsigned       phase;
    int unsigned       item;
    rlsfb_pkg::count_t leds;
    for (phase = 0; phase < PhaseCount; phase++) begin
      if (phase < 4)      gap_pct = 8;
      else if (phase < 8) gap_pct = 61;
      else                gap_pct = 0;
      case (phase)
        0, 4, 8:  leds = rlsfb_pkg::count_t'(16);
        1:        leds = rlsfb_pkg::count_t'(31);
        2:        leds = rlsfb_pkg::count_t'(1);
        5:        leds = rlsfb_pkg::count_t'(20);
        9:        leds = rlsfb_pkg::count_t'(2);
        default:  leds = rlsfb_pkg::count_t'($urandom_range(15, 2));
      endcase
      write_led_count(leds);
      for (item = 0; item < PhaseItems; item++) send_cmd(rand_req());
    end
  endtask

  initial begin : run_tests
    int k;
    for (k = 0; k < rlsfb_pkg::StoreBytes; k++) frame_model[k] = '0;
    led_count = rlsfb_pkg::LedsReset;
    gap_pct   = 8;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_set_rgb();
    test_set_palette();
    test_rotate();
    test_spare_codes();
    test_led_count();
    test_random_traffic();
    settle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
